// File: rtl/core/obd_pkg.sv
// ----------------------------------------------------------------------------
// obd_pkg
// shared constants and types for the orientation basis pipeline
// ----------------------------------------------------------------------------
package obd_pkg;

    // magnitude width after the pre-scale, and the bound it keeps to
    localparam int MAG_W    = 16;
    localparam int MAG_MAX  = 32768;

    // sum of three squares of pre-scaled magnitudes
    localparam int SUM_W    = 32;

    // radicand is the sum shifted up by ROOT_PAD, the root carries NORM_SH fraction bits
    localparam int ROOT_PAD = 28;
    localparam int NORM_SH  = 14;
    localparam int ROOT_W   = 30;
    localparam int REM_W    = 31;

    // result status
    typedef logic [1:0] t_status;
    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_ZERO_DIR   = 2'd1;
    localparam t_status ST_SIDE_DEGEN = 2'd2;

endpackage

// File: rtl/core/obd_if.sv
// ----------------------------------------------------------------------------
// obd_dir_if / obd_basis_if
// valid/ready channels for direction vectors and basis results
// ----------------------------------------------------------------------------
interface obd_dir_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] dir_x;
    logic signed [W-1:0] dir_y;
    logic signed [W-1:0] dir_z;

    modport source (output valid, dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface obd_basis_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] side_x;
    logic signed [W-1:0] side_y;
    logic signed [W-1:0] side_z;
    logic signed [W-1:0] upv_x;
    logic signed [W-1:0] upv_y;
    logic signed [W-1:0] upv_z;
    logic signed [W-1:0] fwd_x;
    logic signed [W-1:0] fwd_y;
    logic signed [W-1:0] fwd_z;
    logic [1:0]          status;

    modport source (output valid, side_x, side_y, side_z, upv_x, upv_y, upv_z,
                    fwd_x, fwd_y, fwd_z, status, input ready);
    modport sink   (input valid, side_x, side_y, side_z, upv_x, upv_y, upv_z,
                    fwd_x, fwd_y, fwd_z, status, output ready);
endinterface

// File: rtl/core/obd_norm.sv
// ----------------------------------------------------------------------------
// obd_norm
// pipelined 3-vector normaliser: pre-scale, sum of squares, one root bit
// per stage, then three long dividers giving one quotient bit per stage
// ----------------------------------------------------------------------------
module obd_norm #(
    parameter int VW = 16,
    parameter int OW = 16,
    parameter int TW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  logic [2:0][VW-1:0]   i_vec,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_valid,
    output logic                 o_zero,
    output logic [2:0][OW-1:0]   o_q,
    output logic [TW-1:0]        o_tag
);
    import obd_pkg::*;

    localparam int OF   = OW - 2;
    localparam int QB   = OF + 1;
    localparam int KMAX = (VW > MAG_W) ? VW - MAG_W : 0;
    localparam int EW   = (VW > MAG_W + 1) ? VW : MAG_W + 1;
    localparam int SHW  = $clog2(KMAX + 2);
    localparam int NW   = MAG_W + OF + NORM_SH + 1;
    localparam int RSW  = REM_W + 2;
    localparam logic [EW-1:0] E_MAX = EW'(MAG_MAX);
    localparam logic [QB-1:0] Q_LIM = {1'b1, {OF{1'b0}}};

    typedef struct packed {
        logic [2:0]    neg;
        logic          zero;
        logic [TW-1:0] tag;
    } t_ctl;

    typedef struct packed {
        logic [SUM_W-1:0]      s;
        logic [2:0][MAG_W-1:0] m;
        t_ctl                  ctl;
    } t_sq_side;

    typedef struct packed {
        logic [ROOT_W-1:0] n;
        t_ctl              ctl;
    } t_dv_side;

    // stage 0: magnitudes and signs
    logic                r0_valid;
    logic [2:0][VW-1:0]  r0_m, n0_m;
    t_ctl                r0_ctl, n0_ctl;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n0_ctl.neg[i] = i_vec[i][VW-1];
            n0_m[i]       = i_vec[i][VW-1] ? (~i_vec[i] + 1'b1) : i_vec[i];
        end
        n0_ctl.zero = (i_vec == '0);
        n0_ctl.tag  = i_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_valid <= 1'b0;
        else if (i_adv) r0_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r0_m   <= n0_m;
            r0_ctl <= n0_ctl;
        end
    end

    // stage 1: common right shift until every magnitude is within range
    logic                  r1_valid;
    logic [2:0][MAG_W-1:0] r1_m, n1_m;
    t_ctl                  r1_ctl;
    logic [KMAX:0]         ok;
    logic [SHW-1:0]        sh;

    always_comb begin
        for (int k = 0; k <= KMAX; k++) begin
            ok[k] = 1'b1;
            for (int i = 0; i < 3; i++) begin
                if ((EW'(r0_m[i]) >> k) > E_MAX) ok[k] = 1'b0;
            end
        end
        sh = SHW'(KMAX);
        for (int k = KMAX; k >= 0; k--) begin
            if (ok[k]) sh = SHW'(k);
        end
        for (int i = 0; i < 3; i++) begin
            n1_m[i] = MAG_W'(EW'(r0_m[i]) >> sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_valid <= 1'b0;
        else if (i_adv) r1_valid <= r0_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_m   <= n1_m;
            r1_ctl <= r0_ctl;
        end
    end

    // stage 2: squares
    logic                  r2_valid;
    logic [2:0][SUM_W-1:0] r2_sq, n2_sq;
    logic [2:0][MAG_W-1:0] r2_m;
    t_ctl                  r2_ctl;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_sq[i] = SUM_W'(r1_m[i]) * SUM_W'(r1_m[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_valid <= 1'b0;
        else if (i_adv) r2_valid <= r1_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_sq  <= n2_sq;
            r2_m   <= r1_m;
            r2_ctl <= r1_ctl;
        end
    end

    // stage 3: sum of squares
    logic     r3_valid;
    t_sq_side r3_side, n3_side;

    always_comb begin
        n3_side.s   = r2_sq[0] + r2_sq[1] + r2_sq[2];
        n3_side.m   = r2_m;
        n3_side.ctl = r2_ctl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_valid <= 1'b0;
        else if (i_adv) r3_valid <= r2_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) r3_side <= n3_side;
    end

    // square root of sum << ROOT_PAD, one root bit per stage
    logic              r_sq_valid [ROOT_W];
    logic [ROOT_W-1:0] r_sq_root  [ROOT_W];
    logic [REM_W-1:0]  r_sq_rem   [ROOT_W];
    t_sq_side          r_sq_side  [ROOT_W];

    for (genvar t = 0; t < ROOT_W; t++) begin : g_sqrt
        localparam int J = ROOT_W - 1 - t;
        logic              in_valid;
        logic [ROOT_W-1:0] in_root;
        logic [REM_W-1:0]  in_rem;
        t_sq_side          in_side;
        logic [1:0]        pair;
        logic [RSW-1:0]    rem_sh;
        logic [RSW-1:0]    trial;
        logic [ROOT_W-1:0] n_root;
        logic [REM_W-1:0]  n_rem;

        if (t == 0) begin : g_first
            assign in_valid = r3_valid;
            assign in_root  = '0;
            assign in_rem   = '0;
            assign in_side  = r3_side;
        end else begin : g_next
            assign in_valid = r_sq_valid[t-1];
            assign in_root  = r_sq_root[t-1];
            assign in_rem   = r_sq_rem[t-1];
            assign in_side  = r_sq_side[t-1];
        end

        // radicand bit pair, zero below the padding
        if (2 * J >= ROOT_PAD) begin : g_bits
            assign pair = in_side.s[2*J-ROOT_PAD+1 -: 2];
        end else begin : g_pad
            assign pair = 2'b00;
        end

        always_comb begin
            rem_sh = {in_rem, pair};
            trial  = RSW'({in_root, 2'b01});
            if (rem_sh >= trial) begin
                n_rem  = REM_W'(rem_sh - trial);
                n_root = {in_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh[REM_W-1:0];
                n_root = {in_root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_valid[t] <= 1'b0;
            else if (i_adv) r_sq_valid[t] <= in_valid;
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_sq_root[t] <= n_root;
                r_sq_rem[t]  <= n_rem;
                r_sq_side[t] <= in_side;
            end
        end
    end

    // dividend m << (OF + NORM_SH) plus half the divisor, split into top and low bits
    logic                   r4_valid;
    logic [2:0][ROOT_W-1:0] r4_rem, n4_rem;
    logic [2:0][QB-1:0]     r4_low, n4_low;
    t_dv_side               r4_side, n4_side;
    logic [2:0][NW-1:0]     dvd;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dvd[i] = (NW'(r_sq_side[ROOT_W-1].m[i]) << (OF + NORM_SH))
                   + NW'(r_sq_root[ROOT_W-1] >> 1);
            n4_rem[i] = dvd[i][NW-1:QB];
            n4_low[i] = dvd[i][QB-1:0];
        end
        n4_side.n   = r_sq_root[ROOT_W-1];
        n4_side.ctl = r_sq_side[ROOT_W-1].ctl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_valid <= 1'b0;
        else if (i_adv) r4_valid <= r_sq_valid[ROOT_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_rem  <= n4_rem;
            r4_low  <= n4_low;
            r4_side <= n4_side;
        end
    end

    // restoring division, one quotient bit per stage for all three lanes
    logic                   r_dv_valid [QB];
    logic [2:0][ROOT_W-1:0] r_dv_rem   [QB];
    logic [2:0][QB-1:0]     r_dv_low   [QB];
    logic [2:0][QB-1:0]     r_dv_q     [QB];
    t_dv_side               r_dv_side  [QB];

    for (genvar u = 0; u < QB; u++) begin : g_div
        localparam int K = QB - 1 - u;
        logic                   in_valid;
        logic [2:0][ROOT_W-1:0] in_rem;
        logic [2:0][QB-1:0]     in_low;
        logic [2:0][QB-1:0]     in_q;
        t_dv_side               in_side;
        logic [2:0][ROOT_W:0]   rem2;
        logic [2:0][ROOT_W-1:0] n_rem;
        logic [2:0][QB-1:0]     n_q;

        if (u == 0) begin : g_first
            assign in_valid = r4_valid;
            assign in_rem   = r4_rem;
            assign in_low   = r4_low;
            assign in_q     = '0;
            assign in_side  = r4_side;
        end else begin : g_next
            assign in_valid = r_dv_valid[u-1];
            assign in_rem   = r_dv_rem[u-1];
            assign in_low   = r_dv_low[u-1];
            assign in_q     = r_dv_q[u-1];
            assign in_side  = r_dv_side[u-1];
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rem2[i] = {in_rem[i], in_low[i][K]};
                if (rem2[i] >= {1'b0, in_side.n}) begin
                    n_rem[i] = ROOT_W'(rem2[i] - {1'b0, in_side.n});
                    n_q[i]   = {in_q[i][QB-2:0], 1'b1};
                end else begin
                    n_rem[i] = rem2[i][ROOT_W-1:0];
                    n_q[i]   = {in_q[i][QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv_valid[u] <= 1'b0;
            else if (i_adv) r_dv_valid[u] <= in_valid;
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_dv_rem[u]  <= n_rem;
                r_dv_low[u]  <= in_low;
                r_dv_q[u]    <= n_q;
                r_dv_side[u] <= in_side;
            end
        end
    end

    // clamp to one and restore the sign
    logic               r_out_valid;
    logic               r_out_zero;
    logic [2:0][OW-1:0] r_out_q, n_out_q;
    logic [TW-1:0]      r_out_tag;
    logic [2:0][QB-1:0] qc;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qc[i]      = (r_dv_q[QB-1][i] > Q_LIM) ? Q_LIM : r_dv_q[QB-1][i];
            n_out_q[i] = r_dv_side[QB-1].ctl.neg[i] ? (~{1'b0, qc[i]} + 1'b1)
                                                    : {1'b0, qc[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (i_adv) r_out_valid <= r_dv_valid[QB-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out_q    <= n_out_q;
            r_out_zero <= r_dv_side[QB-1].ctl.zero;
            r_out_tag  <= r_dv_side[QB-1].ctl.tag;
        end
    end

    assign o_valid = r_out_valid;
    assign o_zero  = r_out_zero;
    assign o_q     = r_out_q;
    assign o_tag   = r_out_tag;

    // pre-scale leaves every magnitude within range
    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_valid |-> (r1_m[0] <= MAG_W'(MAG_MAX)) && (r1_m[1] <= MAG_W'(MAG_MAX))
                  && (r1_m[2] <= MAG_W'(MAG_MAX)))
        else $error("pre-scaled magnitude out of range");

    // a non-zero vector has a root of at least one in root units
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_valid[ROOT_W-1] && !r_sq_side[ROOT_W-1].ctl.zero
        |-> r_sq_root[ROOT_W-1] >= ROOT_W'(1 << NORM_SH))
        else $error("root below unit for non-zero vector");

    // the quotient never exceeds one before the clamp
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_valid[QB-1] && !r_dv_side[QB-1].ctl.zero
        |-> (r_dv_q[QB-1][0] <= Q_LIM) && (r_dv_q[QB-1][1] <= Q_LIM)
         && (r_dv_q[QB-1][2] <= Q_LIM))
        else $error("normalised component above one");

endmodule

// File: rtl/core/obd_cross.sv
// ----------------------------------------------------------------------------
// obd_cross
// recomputed up vector cross(fwd, side), rounding, clamp and status merge
// ----------------------------------------------------------------------------
module obd_cross #(
    parameter int OW = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic [2:0][OW-1:0]  i_fwd,
    input  logic [2:0][OW-1:0]  i_side,
    input  logic                i_zero_dir,
    input  logic                i_zero_side,
    output logic                o_valid,
    output logic [2:0][OW-1:0]  o_side,
    output logic [2:0][OW-1:0]  o_upv,
    output logic [2:0][OW-1:0]  o_fwd,
    output obd_pkg::t_status    o_status
);
    import obd_pkg::*;

    localparam int OF = OW - 2;
    localparam int MW = 2 * OW;
    localparam int PW = 2 * OW + 1;
    localparam logic signed [PW-1:0] P_RND = PW'(1 << (OF - 1));
    localparam logic signed [PW-1:0] P_LIM = PW'(1 << OF);

    // stage p: products
    logic                    r_p_valid;
    logic signed [MW-1:0]    r_pa [3];
    logic signed [MW-1:0]    r_pb [3];
    logic signed [MW-1:0]    n_pa [3];
    logic signed [MW-1:0]    n_pb [3];
    logic [2:0][OW-1:0]      r_p_fwd, r_p_side;
    t_status                 r_p_status, n_p_status;

    always_comb begin
        n_pa[0] = $signed(i_fwd[1]) * $signed(i_side[2]);
        n_pb[0] = $signed(i_fwd[2]) * $signed(i_side[1]);
        n_pa[1] = $signed(i_fwd[2]) * $signed(i_side[0]);
        n_pb[1] = $signed(i_fwd[0]) * $signed(i_side[2]);
        n_pa[2] = $signed(i_fwd[0]) * $signed(i_side[1]);
        n_pb[2] = $signed(i_fwd[1]) * $signed(i_side[0]);
        if (i_zero_dir)       n_p_status = ST_ZERO_DIR;
        else if (i_zero_side) n_p_status = ST_SIDE_DEGEN;
        else                  n_p_status = ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p_valid <= 1'b0;
        else if (i_adv) r_p_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= n_pa[i];
                r_pb[i] <= n_pb[i];
            end
            r_p_fwd    <= i_fwd;
            r_p_side   <= i_side;
            r_p_status <= n_p_status;
        end
    end

    // stage d1: difference plus half an output lsb
    logic                 r_d_valid;
    logic signed [PW-1:0] r_t [3];
    logic signed [PW-1:0] n_t [3];
    logic [2:0][OW-1:0]   r_d_fwd, r_d_side;
    t_status              r_d_status;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i] = PW'(r_pa[i]) - PW'(r_pb[i]) + P_RND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_valid <= 1'b0;
        else if (i_adv) r_d_valid <= r_p_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) r_t[i] <= n_t[i];
            r_d_fwd    <= r_p_fwd;
            r_d_side   <= r_p_side;
            r_d_status <= r_p_status;
        end
    end

    // stage d2: floor shift, clamp, blank on fault
    logic                 r_o_valid;
    logic [2:0][OW-1:0]   r_o_side, r_o_upv, r_o_fwd;
    logic [2:0][OW-1:0]   n_o_side, n_o_upv, n_o_fwd;
    t_status              r_o_status;
    logic signed [PW-1:0] rs [3];
    logic signed [PW-1:0] rc [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rs[i] = r_t[i] >>> OF;
            if (rs[i] > P_LIM)       rc[i] = P_LIM;
            else if (rs[i] < -P_LIM) rc[i] = -P_LIM;
            else                     rc[i] = rs[i];
            n_o_upv[i] = rc[i][OW-1:0];
        end
        n_o_side = r_d_side;
        n_o_fwd  = r_d_fwd;
        if (r_d_status != ST_OK) begin
            n_o_upv  = '0;
            n_o_side = '0;
            n_o_fwd  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else if (i_adv) r_o_valid <= r_d_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_o_side   <= n_o_side;
            r_o_upv    <= n_o_upv;
            r_o_fwd    <= n_o_fwd;
            r_o_status <= r_d_status;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_side   = r_o_side;
    assign o_upv    = r_o_upv;
    assign o_fwd    = r_o_fwd;
    assign o_status = r_o_status;

endmodule

// File: rtl/core/orientation_basis_from_direction.sv
// Throughput: one vector per cycle while no result is held at the output; two
// normalisers each hold a 30-stage root pipeline and OUT_WIDTH-1 stages of long
// division, all stages move together.
// A result waiting at the output freezes the whole pipeline and input ready drops.
// Reset (synchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// orientation_basis_from_direction
// orthonormal basis (side, up, forward) from one direction vector
// ----------------------------------------------------------------------------
module orientation_basis_from_direction #(
    parameter int IN_WIDTH  = 16,
    parameter int OUT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    obd_dir_if.sink           i_dir,
    obd_basis_if.source       o_basis
);
    import obd_pkg::*;

    localparam int OW  = OUT_WIDTH;
    localparam int TW2 = 3 * OW + 1;
    // up is +Y when 100*|y| < 99 * 2^(IN_WIDTH-4)
    localparam logic [63:0] UP_LIM = ((64'd99 << (IN_WIDTH - 4)) - 64'd1) / 64'd100;
    localparam logic signed [OW-1:0] F_LIM = OW'(1 << (OW - 2));

    logic                    adv;
    logic [IN_WIDTH-1:0]     ay;
    logic                    up_y;
    logic [2:0][IN_WIDTH-1:0] dvec;

    logic                    n1_valid, n1_zero;
    logic [2:0][OW-1:0]      n1_f;
    logic [0:0]              n1_tag;
    logic [2:0][OW-1:0]      cvec;

    logic                    n2_valid, n2_zero;
    logic [2:0][OW-1:0]      n2_s;
    logic [TW2-1:0]          n2_tag;
    logic [2:0][OW-1:0]      f_late;

    logic                    c_valid;
    logic [2:0][OW-1:0]      c_side, c_upv, c_fwd;
    t_status                 c_status;

    // whole pipeline advances unless a result is held at the output
    assign adv         = !c_valid || o_basis.ready;
    assign i_dir.ready = adv;

    // up selection on the raw y component
    always_comb begin
        ay   = i_dir.dir_y[IN_WIDTH-1] ? (~i_dir.dir_y + 1'b1) : i_dir.dir_y;
        up_y = (64'(ay) <= UP_LIM);
        dvec = {i_dir.dir_z, i_dir.dir_y, i_dir.dir_x};
    end

    obd_norm #(
        .VW (IN_WIDTH),
        .OW (OW),
        .TW (1)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_dir.valid),
        .i_vec   (dvec),
        .i_tag   (up_y),
        .o_valid (n1_valid),
        .o_zero  (n1_zero),
        .o_q     (n1_f),
        .o_tag   (n1_tag)
    );

    // cross(up, fwd) for the chosen up axis
    always_comb begin
        if (n1_tag[0]) begin
            cvec[0] = n1_f[2];
            cvec[1] = '0;
            cvec[2] = ~n1_f[0] + 1'b1;
        end else begin
            cvec[0] = ~n1_f[1] + 1'b1;
            cvec[1] = n1_f[0];
            cvec[2] = '0;
        end
    end

    obd_norm #(
        .VW (OW),
        .OW (OW),
        .TW (TW2)
    ) u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (n1_valid),
        .i_vec   (cvec),
        .i_tag   ({n1_f, n1_zero}),
        .o_valid (n2_valid),
        .o_zero  (n2_zero),
        .o_q     (n2_s),
        .o_tag   (n2_tag)
    );

    assign f_late = n2_tag[TW2-1:1];

    obd_cross #(
        .OW (OW)
    ) u_cross (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (n2_valid),
        .i_fwd       (f_late),
        .i_side      (n2_s),
        .i_zero_dir  (n2_tag[0]),
        .i_zero_side (n2_zero),
        .o_valid     (c_valid),
        .o_side      (c_side),
        .o_upv       (c_upv),
        .o_fwd       (c_fwd),
        .o_status    (c_status)
    );

    // result transaction
    assign o_basis.valid  = c_valid;
    assign o_basis.side_x = c_side[0];
    assign o_basis.side_y = c_side[1];
    assign o_basis.side_z = c_side[2];
    assign o_basis.upv_x  = c_upv[0];
    assign o_basis.upv_y  = c_upv[1];
    assign o_basis.upv_z  = c_upv[2];
    assign o_basis.fwd_x  = c_fwd[0];
    assign o_basis.fwd_y  = c_fwd[1];
    assign o_basis.fwd_z  = c_fwd[2];
    assign o_basis.status = c_status;

    // a held result blocks new input
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_basis.valid && !o_basis.ready |-> !i_dir.ready)
        else $error("input accepted while result held");

    // a fault result carries zero vectors
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_basis.valid && (o_basis.status != ST_OK)
        |-> (o_basis.side_x == 0) && (o_basis.side_y == 0) && (o_basis.side_z == 0)
         && (o_basis.upv_x == 0) && (o_basis.upv_y == 0) && (o_basis.upv_z == 0)
         && (o_basis.fwd_x == 0) && (o_basis.fwd_y == 0) && (o_basis.fwd_z == 0))
        else $error("non-zero vector on fault status");

    // forward components stay within plus or minus one
    a_fwd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_basis.valid && (o_basis.status == ST_OK)
        |-> (o_basis.fwd_x <= F_LIM) && (o_basis.fwd_x >= -F_LIM)
         && (o_basis.fwd_y <= F_LIM) && (o_basis.fwd_y >= -F_LIM)
         && (o_basis.fwd_z <= F_LIM) && (o_basis.fwd_z >= -F_LIM))
        else $error("forward component out of range");

endmodule

// File: tb/sv/obd_basis_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obd_basis_checker
// watches the direction and basis channels, works out the expected basis for
// every accepted direction and compares each accepted result field by field
// ----------------------------------------------------------------------------
module obd_basis_checker #(
    parameter int IN_WIDTH  = 16,
    parameter int OUT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    obd_dir_if          i_dir,
    obd_basis_if        i_basis,
    output int          o_fail_count,
    output int          o_pending
);
    import obd_pkg::*;

    localparam int OF = OUT_WIDTH - 2;

    typedef struct {
        logic signed [OUT_WIDTH-1:0] v [9];
        t_status                     status;
    } t_basis;

    t_basis basis_q[$];
    int     fail_count;
    int     pending;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    // unit vector of an integer vector, false when the vector is zero
    function automatic bit unit_vec(input longint v [3], output longint q [3]);
        longint unsigned m [3];
        longint unsigned sum, root, rem, bitv, r;
        m[0] = (v[0] < 0) ? -v[0] : v[0];
        m[1] = (v[1] < 0) ? -v[1] : v[1];
        m[2] = (v[2] < 0) ? -v[2] : v[2];
        if (m[0] == 0 && m[1] == 0 && m[2] == 0) return 1'b0;
        while (m[0] > 32768 || m[1] > 32768 || m[2] > 32768) begin
            m[0] = m[0] >> 1;
            m[1] = m[1] >> 1;
            m[2] = m[2] >> 1;
        end
        sum  = (m[0] * m[0] + m[1] * m[1] + m[2] * m[2]) << 28;
        // bitwise integer square root
        root = 0;
        rem  = sum;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        if (root == 0) return 1'b0;
        for (int i = 0; i < 3; i++) begin
            r = ((m[i] << (OF + 14)) + (root >> 1)) / root;
            if (r > (64'd1 << OF)) r = 64'd1 << OF;
            q[i] = (v[i] < 0) ? -longint'(r) : longint'(r);
        end
        return 1'b1;
    endfunction

    // round a Q2.2OF product to Q1.OF, halves upward, then clamp
    function automatic longint round_q(input longint p);
        longint r;
        longint lim;
        lim = longint'(1) << OF;
        r   = (p + (longint'(1) << (OF - 1))) >>> OF;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_basis basis_of(input logic signed [IN_WIDTH-1:0] dx,
                                        input logic signed [IN_WIDTH-1:0] dy,
                                        input logic signed [IN_WIDTH-1:0] dz);
        t_basis b;
        longint d [3], f [3], c [3], s [3], u [3];
        longint ay;
        foreach (b.v[i]) b.v[i] = '0;
        d[0] = longint'(dx);
        d[1] = longint'(dy);
        d[2] = longint'(dz);
        ay = (d[1] < 0) ? -d[1] : d[1];
        if (!unit_vec(d, f)) begin
            b.status = ST_ZERO_DIR;
            return b;
        end
        // up is +Y unless 100*|y| reaches 99 * 2^(IN_WIDTH-4)
        if (ay * 100 < 99 * (longint'(1) << (IN_WIDTH - 4))) begin
            c[0] = f[2]; c[1] = 0; c[2] = -f[0];
        end else begin
            c[0] = -f[1]; c[1] = f[0]; c[2] = 0;
        end
        if (!unit_vec(c, s)) begin
            b.status = ST_SIDE_DEGEN;
            return b;
        end
        u[0] = round_q(f[1] * s[2] - f[2] * s[1]);
        u[1] = round_q(f[2] * s[0] - f[0] * s[2]);
        u[2] = round_q(f[0] * s[1] - f[1] * s[0]);
        for (int i = 0; i < 3; i++) begin
            b.v[i]     = OUT_WIDTH'(s[i]);
            b.v[3 + i] = OUT_WIDTH'(u[i]);
            b.v[6 + i] = OUT_WIDTH'(f[i]);
        end
        b.status = ST_OK;
        return b;
    endfunction

    // predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        t_basis exp_b;
        t_basis got;
        string  names [9];
        names = '{"side_x", "side_y", "side_z", "upv_x", "upv_y", "upv_z",
                  "fwd_x", "fwd_y", "fwd_z"};
        if (!i_rst_n) begin
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (i_dir.valid && i_dir.ready)
                basis_q.push_back(basis_of(i_dir.dir_x, i_dir.dir_y, i_dir.dir_z));
            if (i_basis.valid && i_basis.ready) begin
                got.v = '{i_basis.side_x, i_basis.side_y, i_basis.side_z,
                          i_basis.upv_x, i_basis.upv_y, i_basis.upv_z,
                          i_basis.fwd_x, i_basis.fwd_y, i_basis.fwd_z};
                got.status = i_basis.status;
                if (basis_q.size() == 0) begin
                    $error("basis result with no direction outstanding");
                    fail_count <= fail_count + 1;
                end else begin
                    int errs;
                    exp_b = basis_q.pop_front();
                    errs  = 0;
                    for (int i = 0; i < 9; i++)
                        if (got.v[i] !== exp_b.v[i]) begin
                            $error("%s expected %0d got %0d", names[i], exp_b.v[i],
                                   got.v[i]);
                            errs++;
                        end
                    if (got.status !== exp_b.status) begin
                        $error("status expected %0d got %0d", exp_b.status, got.status);
                        errs++;
                    end
                    if (errs != 0) fail_count <= fail_count + 1;
                end
            end
            pending <= basis_q.size();
        end
    end

endmodule

// File: tb/sv/tb_orientation_basis_from_direction.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_orientation_basis_from_direction
// directed and random direction vectors under varying idle and stall patterns;
// results are checked by obd_basis_checker
// ----------------------------------------------------------------------------
module tb_orientation_basis_from_direction;
    import obd_pkg::*;

    localparam int IN_WIDTH  = 16;
    localparam int OUT_WIDTH = 16;
    localparam int LATENCY   = 2 * OUT_WIDTH + 73;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_off;

    obd_dir_if   #(.W(IN_WIDTH))  dir_ch ();
    obd_basis_if #(.W(OUT_WIDTH)) basis_ch ();

    orientation_basis_from_direction #(
        .IN_WIDTH (IN_WIDTH),
        .OUT_WIDTH(OUT_WIDTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_dir  (dir_ch),
        .o_basis(basis_ch)
    );

    obd_basis_checker #(
        .IN_WIDTH (IN_WIDTH),
        .OUT_WIDTH(OUT_WIDTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dir       (dir_ch),
        .i_basis     (basis_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random stalls, or a long hold-off
    initial begin
        basis_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            basis_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one direction transaction, with random idle cycles first
    task automatic send_dir(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            dir_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        dir_ch.valid <= 1'b1;
        dir_ch.dir_x <= x;
        dir_ch.dir_y <= y;
        dir_ch.dir_z <= z;
        do @(posedge i_clk); while (!dir_ch.ready);
    endtask

    task automatic drain_results();
        dir_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    // random direction: mostly full range, some small, some near +-y threshold
    task automatic send_random();
        logic [15:0] c [3];
        int          k;
        k = $urandom_range(9);
        for (int i = 0; i < 3; i++) c[i] = 16'($urandom);
        if (k < 2) begin
            for (int i = 0; i < 3; i++) c[i] = 16'($urandom_range(8) - 4);
        end else if (k < 4) begin
            c[1] = 16'(($urandom_range(1) ? 16'd4055 : -16'd4055)
                       + $urandom_range(6) - 3);
            c[0] = $urandom_range(1) ? 16'd0 : c[0] >>> $urandom_range(15);
            c[2] = $urandom_range(1) ? 16'd0 : c[2] >>> $urandom_range(15);
        end else if (k == 4) begin
            c[$urandom_range(2)] = 16'd0;
        end
        send_dir(c[0], c[1], c[2]);
    endtask

    initial begin
        logic [15:0] dirs [][3];
        dir_ch.valid   = 1'b0;
        dir_ch.dir_x   = '0;
        dir_ch.dir_y   = '0;
        dir_ch.dir_z   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        i_rst_n        = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero, axes, extremes, y threshold, degenerate side
        dirs = '{'{16'h0000, 16'h0000, 16'h0000}, '{16'h1000, 16'h0000, 16'h0000},
                 '{16'h0000, 16'h1000, 16'h0000}, '{16'h0000, 16'h0000, 16'h1000},
                 '{16'h8000, 16'h8000, 16'h8000}, '{16'h7FFF, 16'h7FFF, 16'h7FFF},
                 '{16'h8000, 16'h0000, 16'h0000}, '{16'h0000, 16'h8000, 16'h0000},
                 '{16'h0000, 16'h0000, 16'h8000}, '{16'h7FFF, 16'h8000, 16'h0001},
                 '{16'h0001, 16'h0000, 16'h0000}, '{16'h0000, 16'hFFFF, 16'h0000},
                 '{16'h0000, 16'h0FD7, 16'h0000}, '{16'h0000, 16'h0FD8, 16'h0000},
                 '{16'h0001, 16'h0FD7, 16'h0000}, '{16'h0001, 16'h0FD8, 16'h0001},
                 '{16'h0000, 16'hF029, 16'h0001}, '{16'h0000, 16'hF028, 16'h0300},
                 '{16'h0001, 16'h0000, 16'h0000}, '{16'hFFFF, 16'h0001, 16'hFFFF},
                 '{16'h5555, 16'hAAAA, 16'h5555}, '{16'h0000, 16'h0000, 16'hFFFF}};
        foreach (dirs[i]) send_dir(dirs[i][0], dirs[i][1], dirs[i][2]);
        drain_results();

        // random phases with different idle and stall mixes
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                3: begin send_idle_pct = 26; recv_stall_pct = 26; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) begin
                // long output hold-off while inputs keep coming
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                    repeat (200) send_random();
                join
            end else begin
                repeat (220) send_random();
            end
            drain_results();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (LATENCY + 20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/obd_pkg.sv
rtl/core/obd_if.sv
rtl/core/obd_norm.sv
rtl/core/obd_cross.sv
rtl/core/orientation_basis_from_direction.sv
tb/sv/obd_basis_checker.sv
tb/sv/tb_orientation_basis_from_direction.sv
